@@ design/icad_pkg.sv @@
// ----------------------------------------------------------------------------
// icad_pkg: shared types and constants
// Step codes, controller command and datapath status for the image-charge
// action difference block.
// ----------------------------------------------------------------------------
package icad_pkg;

    localparam int MUL_AW = 49;                 // multiplicand width
    localparam int MUL_BW = 39;                 // multiplier width
    localparam int PROD_W = MUL_AW + MUL_BW;
    localparam int SUM_W  = 70;                 // sum of three squares
    localparam int ROOT_W = SUM_W / 2;
    localparam int TERM_W = 48;

    localparam logic [TERM_W-1:0] LIM_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [TERM_W-1:0] LIM_NEG = 48'h8000_0000_0000;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DONOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BARRIER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd6;

    typedef enum logic [3:0] {
        STEP_SQX,
        STEP_SQY,
        STEP_SQA,
        STEP_ROOT,
        STEP_QONE,
        STEP_QTWO,
        STEP_IMG,
        STEP_TERM,
        STEP_SCALE,
        STEP_ACCUM
    } step_t;

    typedef struct packed {
        logic  start;   // launch the unit that serves step
        logic  exec;    // one-cycle register update for step
        logic  emit;    // result waiting for the output register
        logic  pos;     // 0: new position, 1: old position
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic done;     // running unit finished
        logic in_range; // held index lies in the species range
        logic last;     // held request closes the move
        logic out_free; // output register can take a result
    } status_t;

endpackage

@@ design/icad_mul.sv @@
// ----------------------------------------------------------------------------
// icad_mul: shift-add multiplier
// Unsigned product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module icad_mul #(
    parameter int AW = 49,
    parameter int BW = 39
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic            done,
    output logic [AW+BW-1:0] prod
);

    localparam int CW = $clog2(BW + 1);

    logic [AW-1:0]    a_reg;
    logic [AW+BW-1:0] p_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [AW:0]      part;

    assign part = {1'b0, p_reg[AW+BW-1:BW]} + (p_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(BW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift the partial product right, add the multiplicand on a one bit
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            p_reg <= {{AW{1'b0}}, b};
        end else if (busy_reg) begin
            p_reg <= {part, p_reg[BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

@@ design/icad_div.sv @@
// ----------------------------------------------------------------------------
// icad_div: restoring divider
// Divides a power of two by an unsigned divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module icad_div #(
    parameter int QW = 42,
    parameter int DW = 35
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [$clog2(QW)-1:0] expo,
    input  logic [DW-1:0]         divisor,
    output logic                  done,
    output logic [QW-1:0]         quo
);

    localparam int CW = $clog2(QW);

    logic [DW-1:0] dvs_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] q_reg;
    logic [CW-1:0] exp_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem2;
    logic [DW:0]   diff;
    logic          ge;

    assign rem2 = {rem_reg, (cnt_reg == exp_reg)};
    assign diff = rem2 - {1'b0, dvs_reg};
    assign ge   = rem2 >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            exp_reg <= expo;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DW-1:0] : rem2[DW-1:0];
            q_reg   <= {q_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

@@ design/icad_sqrt.sv @@
// ----------------------------------------------------------------------------
// icad_sqrt: digit-by-digit integer square root
// Floor root of an unsigned word, one root bit per cycle.
// ----------------------------------------------------------------------------
module icad_sqrt #(
    parameter int NW = 70
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NW-1:0]     radicand,
    output logic              done,
    output logic [NW/2-1:0]   root
);

    localparam int RW = NW / 2;
    localparam int CW = $clog2(RW + 1);

    logic [NW-1:0] n_reg;
    logic [RW-1:0] root_reg;
    logic [RW:0]   rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [RW+2:0] rem4;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    assign rem4  = {rem_reg, n_reg[NW-1:NW-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign diff  = rem4 - trial;
    assign ge    = rem4 >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg    <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            n_reg    <= {n_reg[NW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW:0] : rem4[RW:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ design/icad_datapath.sv @@
// ----------------------------------------------------------------------------
// icad_datapath: registers and arithmetic units
// Holds configuration, the current request, intermediate terms, the running
// sum and the output register; runs the shared multiplier, divider and root.
// ----------------------------------------------------------------------------
module icad_datapath #(
    parameter int MAX_PARTICLES   = 1024,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [icad_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_load,
    input  logic [207:0]                       in_data,
    input  logic                               in_last,
    input  icad_pkg::cmd_t                     cmd,
    output icad_pkg::status_t                  status,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [55:0]                        m_tdata
);

    localparam int QW   = 26 + COORD_FRAC_BITS;
    localparam int EXPW = $clog2(QW);
    localparam logic [EXPW-1:0] EXP_ONE = EXPW'(25 + COORD_FRAC_BITS);
    localparam logic [EXPW-1:0] EXP_TWO = EXPW'(23 + COORD_FRAC_BITS);
    localparam int AW = icad_pkg::MUL_AW;
    localparam int BW = icad_pkg::MUL_BW;
    localparam int PW = icad_pkg::PROD_W;
    localparam int SW = icad_pkg::SUM_W;
    localparam int RW = icad_pkg::ROOT_W;
    localparam int TW = icad_pkg::TERM_W;

    // configuration
    logic [30:0]        donor_reg;
    logic [30:0]        shift_reg;
    logic signed [31:0] barrier_reg;
    logic signed [31:0] strength_reg;
    logic [31:0]        time_reg;
    logic [9:0]         first_reg;
    logic [10:0]        count_reg;

    // held request
    logic [9:0]         idx_reg;
    logic signed [31:0] new_x_reg, new_y_reg, new_z_reg;
    logic signed [31:0] old_x_reg, old_y_reg, old_z_reg;
    logic [2:0]         level_reg;
    logic               last_reg;

    // intermediate values
    logic [SW-1:0]      sq_sum_reg;
    logic [RW-1:0]      root_reg;
    logic [TW-1:0]      q1_reg, q2_reg, q24_reg, en_reg, eo_reg;
    logic               neg_reg;
    logic [TW-1:0]      acc_reg;
    logic               flag_reg;
    logic               m_valid_reg;
    logic [55:0]        m_data_reg;

    logic signed [31:0] px, py, pz;
    logic [31:0]        x_mag, y_mag, str_mag;
    logic [31:0]        s_sum;
    logic [34:0]        a_val, a_neg;
    logic [33:0]        a_mag;
    logic [33:0]        den, den_neg;
    logic [32:0]        den_mag;
    logic               below;
    logic [48:0]        barrier_ext;
    logic [48:0]        qd, qd_neg, ed, ed_neg;
    logic [47:0]        qd_mag;
    logic [48:0]        ed_mag;
    logic [BW-1:0]      kt;
    logic [11:0]        range_end;

    logic               mul_go, div_go, sqrt_go;
    logic [AW-1:0]      mul_a;
    logic [BW-1:0]      mul_b;
    logic [PW-1:0]      mul_p;
    logic               mul_done, div_done, sqrt_done;
    logic [EXPW-1:0]    div_exp;
    logic [RW-1:0]      div_dvs;
    logic [QW-1:0]      div_q;
    logic [RW-1:0]      sqrt_r;

    logic [48:0]        q24_res;
    logic [48:0]        q_clamp;
    logic [48:0]        term_res;
    logic [48:0]        acc_res;
    logic               root_zero, den_zero;
    logic               fire;

    // {saturated, value}: magnitude product scaled back by 24 fraction bits
    function automatic logic [48:0] q24_sat(input logic [PW-1:0] p, input logic neg);
        logic [63:0] m;
        logic [63:0] lim;
        logic        sat;
        logic [47:0] v;
        m   = p[87:24];
        lim = neg ? {16'd0, icad_pkg::LIM_NEG} : {16'd0, icad_pkg::LIM_POS};
        sat = m > lim;
        v   = sat ? lim[47:0] : m[47:0];
        return {sat, neg ? (48'd0 - v) : v};
    endfunction

    // {saturated, value}: 49-bit signed sum into the 48-bit range
    function automatic logic [48:0] clamp48(input logic [48:0] v);
        logic sat;
        sat = v[48] != v[47];
        if (sat) begin
            return {1'b1, v[48] ? icad_pkg::LIM_NEG : icad_pkg::LIM_POS};
        end
        return {1'b0, v[47:0]};
    endfunction

    // operand selection for the current position
    assign px = cmd.pos ? old_x_reg : new_x_reg;
    assign py = cmd.pos ? old_y_reg : new_y_reg;
    assign pz = cmd.pos ? old_z_reg : new_z_reg;

    assign x_mag   = px[31] ? (32'd0 - px) : px;
    assign y_mag   = py[31] ? (32'd0 - py) : py;
    assign str_mag = strength_reg[31] ? (32'd0 - strength_reg) : strength_reg;

    assign s_sum   = {1'b0, donor_reg} + {1'b0, shift_reg};
    assign a_val   = {{3{pz[31]}}, pz} + {2'b00, s_sum, 1'b0};
    assign a_neg   = 35'd0 - a_val;
    assign a_mag   = a_val[34] ? a_neg[33:0] : a_val[33:0];
    assign den     = {{2{pz[31]}}, pz} + {2'b00, s_sum};
    assign den_neg = 34'd0 - den;
    assign den_mag = den[33] ? den_neg[32:0] : den[32:0];
    assign den_zero = den == '0;
    assign root_zero = root_reg == '0;

    assign below = $signed({pz[31], pz}) < $signed(33'd0 - {2'b00, donor_reg});
    assign barrier_ext = below ? {{9{barrier_reg[31]}}, barrier_reg, 8'd0} : 49'd0;

    assign qd     = {q1_reg[47], q1_reg} - {q2_reg[47], q2_reg};
    assign qd_neg = 49'd0 - qd;
    assign qd_mag = qd[48] ? qd_neg[47:0] : qd[47:0];
    assign ed     = {en_reg[47], en_reg} - {eo_reg[47], eo_reg};
    assign ed_neg = 49'd0 - ed;
    assign ed_mag = ed[48] ? ed_neg : ed;
    assign kt     = {7'd0, time_reg} << level_reg;

    assign range_end = {2'b00, first_reg} + {1'b0, count_reg};

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_go = 1'b0;
        case (cmd.step)
            icad_pkg::STEP_SQX: begin
                mul_a  = {17'd0, x_mag};
                mul_b  = {7'd0, x_mag};
                mul_go = cmd.start;
            end
            icad_pkg::STEP_SQY: begin
                mul_a  = {17'd0, y_mag};
                mul_b  = {7'd0, y_mag};
                mul_go = cmd.start;
            end
            icad_pkg::STEP_SQA: begin
                mul_a  = {15'd0, a_mag};
                mul_b  = {5'd0, a_mag};
                mul_go = cmd.start;
            end
            icad_pkg::STEP_IMG: begin
                mul_a  = {1'b0, qd_mag};
                mul_b  = {7'd0, str_mag};
                mul_go = cmd.start;
            end
            icad_pkg::STEP_SCALE: begin
                mul_a  = ed_mag;
                mul_b  = kt;
                mul_go = cmd.start;
            end
            default: ;
        endcase
    end

    assign sqrt_go = cmd.start && (cmd.step == icad_pkg::STEP_ROOT);
    assign div_go  = cmd.start && (cmd.step == icad_pkg::STEP_QONE ||
                                   cmd.step == icad_pkg::STEP_QTWO);
    assign div_exp = (cmd.step == icad_pkg::STEP_QONE) ? EXP_ONE : EXP_TWO;
    assign div_dvs = (cmd.step == icad_pkg::STEP_QONE) ? root_reg : {2'b00, den_mag};

    icad_mul #(.AW(AW), .BW(BW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_go),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_p)
    );

    icad_div #(.QW(QW), .DW(RW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go),
        .expo    (div_exp),
        .divisor (div_dvs),
        .done    (div_done),
        .quo     (div_q)
    );

    icad_sqrt #(.NW(SW)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_go),
        .radicand (sq_sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_r)
    );

    assign q24_res  = q24_sat(mul_p, neg_reg);
    assign q_clamp  = (64'(div_q) > {16'd0, icad_pkg::LIM_POS}) ?
                      {1'b1, icad_pkg::LIM_POS} : {1'b0, 48'(div_q)};
    assign term_res = clamp48(barrier_ext + {q24_reg[47], q24_reg});
    assign acc_res  = clamp48({acc_reg[47], acc_reg} + {q24_reg[47], q24_reg});

    assign fire = cmd.emit && status.out_free;

    // configuration writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            donor_reg    <= 31'd65536;
            shift_reg    <= '0;
            barrier_reg  <= '0;
            strength_reg <= '0;
            time_reg     <= 32'd16777216;
            first_reg    <= '0;
            count_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                icad_pkg::REG_DONOR:    donor_reg    <= cfg_data[30:0];
                icad_pkg::REG_SHIFT:    shift_reg    <= cfg_data[30:0];
                icad_pkg::REG_BARRIER:  barrier_reg  <= cfg_data;
                icad_pkg::REG_STRENGTH: strength_reg <= cfg_data;
                icad_pkg::REG_TIME:     time_reg     <= cfg_data;
                icad_pkg::REG_FIRST:    first_reg    <= cfg_data[9:0];
                icad_pkg::REG_COUNT:    count_reg    <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // request capture and intermediate results
    always_ff @(posedge aclk) begin
        if (in_load) begin
            idx_reg   <= in_data[9:0];
            new_x_reg <= in_data[41:10];
            new_y_reg <= in_data[73:42];
            new_z_reg <= in_data[105:74];
            old_x_reg <= in_data[137:106];
            old_y_reg <= in_data[169:138];
            old_z_reg <= in_data[201:170];
            level_reg <= in_data[204:202];
            last_reg  <= in_last;
        end
        if (cmd.start && cmd.step == icad_pkg::STEP_IMG) begin
            neg_reg <= qd[48] ^ strength_reg[31];
        end
        if (cmd.start && cmd.step == icad_pkg::STEP_SCALE) begin
            neg_reg <= ed[48];
        end
        if (mul_done) begin
            case (cmd.step)
                icad_pkg::STEP_SQX: sq_sum_reg <= mul_p[SW-1:0];
                icad_pkg::STEP_SQY,
                icad_pkg::STEP_SQA: sq_sum_reg <= sq_sum_reg + mul_p[SW-1:0];
                default:            q24_reg    <= q24_res[47:0];
            endcase
        end
        if (sqrt_done) begin
            root_reg <= sqrt_r;
        end
        if (div_done) begin
            if (cmd.step == icad_pkg::STEP_QONE) begin
                q1_reg <= root_zero ? icad_pkg::LIM_POS : q_clamp[47:0];
            end else begin
                q2_reg <= den_zero ? icad_pkg::LIM_POS :
                          (den[33] ? (48'd0 - q_clamp[47:0]) : q_clamp[47:0]);
            end
        end
        if (cmd.exec && cmd.step == icad_pkg::STEP_TERM) begin
            if (cmd.pos) begin
                eo_reg <= term_res[47:0];
            end else begin
                en_reg <= term_res[47:0];
            end
        end
        if (fire) begin
            m_data_reg <= {7'd0, flag_reg, acc_reg};
        end
    end

    // running sum, sticky flag and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                acc_reg  <= '0;
                flag_reg <= 1'b0;
            end else begin
                if (cmd.exec && cmd.step == icad_pkg::STEP_ACCUM) begin
                    acc_reg <= acc_res[47:0];
                    if (acc_res[48]) flag_reg <= 1'b1;
                end
                if (cmd.exec && cmd.step == icad_pkg::STEP_TERM && term_res[48]) begin
                    flag_reg <= 1'b1;
                end
                if (mul_done && q24_res[48] && (cmd.step == icad_pkg::STEP_IMG ||
                                                cmd.step == icad_pkg::STEP_SCALE)) begin
                    flag_reg <= 1'b1;
                end
                if (div_done && cmd.step == icad_pkg::STEP_QONE && (root_zero || q_clamp[48])) begin
                    flag_reg <= 1'b1;
                end
                if (div_done && cmd.step == icad_pkg::STEP_QTWO && (den_zero || q_clamp[48])) begin
                    flag_reg <= 1'b1;
                end
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.done     = mul_done | div_done | sqrt_done;
    assign status.in_range = (idx_reg >= first_reg) && ({2'b00, idx_reg} < range_end) &&
                             ({22'd0, idx_reg} < 32'(MAX_PARTICLES));
    assign status.last     = last_reg;
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ design/icad_ctrl.sv @@
// ----------------------------------------------------------------------------
// icad_ctrl: sequencing state machine
// Walks each in-range request through squares, root, quotients, image term
// and scaling; the last request hands the sum to the output register.
// ----------------------------------------------------------------------------
module icad_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  icad_pkg::status_t status,
    output logic              s_tready,
    output icad_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQX,
        ST_SQY,
        ST_SQA,
        ST_ROOT,
        ST_QONE,
        ST_QTWO,
        ST_IMG,
        ST_TERM,
        ST_SCALE,
        ST_ACCUM,
        ST_EMIT
    } state_t;

    state_t         state_reg;
    logic           ready_reg;
    icad_pkg::cmd_t cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
            cmd_reg   <= '{start: 1'b0, exec: 1'b0, emit: 1'b0, pos: 1'b0,
                           step: icad_pkg::STEP_SQX};
        end else begin
            cmd_reg.start <= 1'b0;
            cmd_reg.exec  <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && ready_reg) begin
                        ready_reg <= 1'b0;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (status.in_range) begin
                        state_reg     <= ST_SQX;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.step  <= icad_pkg::STEP_SQX;
                        cmd_reg.pos   <= 1'b0;
                    end else if (status.last) begin
                        state_reg    <= ST_EMIT;
                        cmd_reg.emit <= 1'b1;
                    end else begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                ST_SQX: begin
                    if (status.done) begin
                        state_reg     <= ST_SQY;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.step  <= icad_pkg::STEP_SQY;
                    end
                end
                ST_SQY: begin
                    if (status.done) begin
                        state_reg     <= ST_SQA;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.step  <= icad_pkg::STEP_SQA;
                    end
                end
                ST_SQA: begin
                    if (status.done) begin
                        state_reg     <= ST_ROOT;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.step  <= icad_pkg::STEP_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (status.done) begin
                        state_reg     <= ST_QONE;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.step  <= icad_pkg::STEP_QONE;
                    end
                end
                ST_QONE: begin
                    if (status.done) begin
                        state_reg     <= ST_QTWO;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.step  <= icad_pkg::STEP_QTWO;
                    end
                end
                ST_QTWO: begin
                    if (status.done) begin
                        state_reg     <= ST_IMG;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.step  <= icad_pkg::STEP_IMG;
                    end
                end
                ST_IMG: begin
                    if (status.done) begin
                        state_reg    <= ST_TERM;
                        cmd_reg.exec <= 1'b1;
                        cmd_reg.step <= icad_pkg::STEP_TERM;
                    end
                end
                ST_TERM: begin
                    cmd_reg.start <= 1'b1;
                    if (!cmd_reg.pos) begin
                        state_reg    <= ST_SQX;
                        cmd_reg.step <= icad_pkg::STEP_SQX;
                        cmd_reg.pos  <= 1'b1;
                    end else begin
                        state_reg    <= ST_SCALE;
                        cmd_reg.step <= icad_pkg::STEP_SCALE;
                    end
                end
                ST_SCALE: begin
                    if (status.done) begin
                        state_reg    <= ST_ACCUM;
                        cmd_reg.exec <= 1'b1;
                        cmd_reg.step <= icad_pkg::STEP_ACCUM;
                    end
                end
                ST_ACCUM: begin
                    if (status.last) begin
                        state_reg    <= ST_EMIT;
                        cmd_reg.emit <= 1'b1;
                    end else begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (status.out_free) begin
                        cmd_reg.emit <= 1'b0;
                        state_reg    <= ST_IDLE;
                        ready_reg    <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_tready = ready_reg;
    assign cmd      = cmd_reg;

endmodule

@@ design/image_charge_action_difference.sv @@
// ----------------------------------------------------------------------------
// image_charge_action_difference: image-charge action difference accumulator
// Sums the scaled change in barrier plus image-charge potential over the
// beads of a move and returns the total on the bead marked last.
// ----------------------------------------------------------------------------
// Each request carries a particle index, new and old bead positions (Q16.16)
// and a level. Requests whose index lies in the species range have, for both
// positions, three squares, a square root and two reciprocals worked out on
// shared bit-serial units, then the potential difference is scaled by
// time_step * 2^level and added to a 48-bit Q24.24 sum. One request is in
// flight at a time: an in-range request runs two passes of three 39-step
// multiplies, a 35-step root, two (26 + COORD_FRAC_BITS)-step divides and a
// multiply, plus a final scaling multiply; an out-of-range request only
// passes the index check, and one that carries tlast then emits the sum. The
// multiplier, divider and root unit run one after another. On a request
// with tlast high the sum and the saturation flag go to the output register
// and are cleared; the next request is taken while that result still waits
// on m_tready. Configuration writes are always taken and must only arrive
// while the block is idle.
// ----------------------------------------------------------------------------
module image_charge_action_difference #(
    parameter int MAX_PARTICLES   = 1024,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [icad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // particle_index[9:0], new_x[41:10], new_y[73:42], new_z[105:74],
    // old_x[137:106], old_y[169:138], old_z[201:170], level[204:202], zero pad
    input  logic [207:0]                   s_tdata,
    input  logic                           s_tlast,   // last
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // action_difference[47:0], saturated[48], zero pad
    output logic [55:0]                    m_tdata
);

    icad_pkg::cmd_t    cmd;
    icad_pkg::status_t status;
    logic              in_load;

    // register writes never stall
    assign cfg_ready = 1'b1;
    assign in_load   = s_tvalid & s_tready;

    icad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    icad_datapath #(
        .MAX_PARTICLES   (MAX_PARTICLES),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_load   (in_load),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    // one request at a time: acceptance closes the input until work ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // a unit never finishes while the block waits for a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |-> !s_tready)
        else $error("arithmetic unit finished while idle");

    // a pending result moves into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.out_free) |=> (m_tvalid && !cmd.emit))
        else $error("result not loaded into output register");

endmodule

@@ dv/image_charge_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image_charge_checker: scoreboard for the action difference accumulator
// Watches configuration, request and result channels, predicts each move's
// summed action change and saturation flag, and compares every result.
// ----------------------------------------------------------------------------
module image_charge_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [icad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [207:0]                   s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [55:0]                    m_tdata,
    output int                             fail_count,
    output int                             pending
);
    import icad_pkg::*;

    localparam int     FRAC     = 16;
    localparam int     NPART    = 1024;
    localparam longint TERM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint TERM_MIN = -64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic [47:0] action;
        logic        sat;
    } move_result_t;

    move_result_t sums_due[$];

    longint donor, shift, barrier, strength, tau, first_idx, count;
    longint action_sum;
    logic   clamp_seen;

    assign pending = sums_due.size();

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clamp_term(longint v);
        if (v > TERM_MAX) begin
            clamp_seen = 1'b1;
            return TERM_MAX;
        end
        if (v < TERM_MIN) begin
            clamp_seen = 1'b1;
            return TERM_MIN;
        end
        return v;
    endfunction

    // exact product, truncated toward zero to 24 fraction bits
    function automatic longint mul_fix24(longint a, longint b);
        logic         neg;
        logic [127:0] p;
        logic [127:0] lim;
        neg = (a < 0) != (b < 0);
        p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> 24;
        lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        if (p > lim) begin
            clamp_seen = 1'b1;
            p = lim;
        end
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic logic [127:0] square(longint v);
        return {64'd0, magnitude(v)} * {64'd0, magnitude(v)};
    endfunction

    function automatic logic [63:0] int_root(logic [127:0] sum);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 40; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= sum)
                r = c;
        end
        return r;
    endfunction

    function automatic longint clamp_quot(logic [63:0] q);
        if (q > 64'(TERM_MAX)) begin
            clamp_seen = 1'b1;
            return TERM_MAX;
        end
        return longint'(q);
    endfunction

    // barrier plus image-charge potential at one bead position
    function automatic longint potential(longint x, longint y, longint z);
        longint       s, a, den, bar, q1, q2, img;
        logic [127:0] sum;
        logic [63:0]  r;
        s = donor + shift;
        a = z + 2 * s;
        den = z + s;
        bar = (z < -donor) ? barrier * 256 : 0;
        sum = square(x) + square(y) + square(a);
        r = int_root(sum);
        if (r == 0) begin
            clamp_seen = 1'b1;
            q1 = TERM_MAX;
        end else begin
            q1 = clamp_quot((64'd1 << (25 + FRAC)) / r);
        end
        if (den == 0) begin
            clamp_seen = 1'b1;
            q2 = TERM_MAX;
        end else begin
            q2 = clamp_quot((64'd1 << (23 + FRAC)) / magnitude(den));
            if (den < 0)
                q2 = -q2;
        end
        img = mul_fix24(q1 - q2, strength);
        return clamp_term(bar + img);
    endfunction

    task automatic accept_bead(logic [207:0] d, logic is_last);
        longint idx, stop, en, eo, kt;
        idx = longint'(d[9:0]);
        stop = first_idx + count;
        if (stop > NPART)
            stop = NPART;
        if (idx >= first_idx && idx < stop) begin
            en = potential($signed(d[41:10]), $signed(d[73:42]), $signed(d[105:74]));
            eo = potential($signed(d[137:106]), $signed(d[169:138]),
                           $signed(d[201:170]));
            kt = tau << d[204:202];
            action_sum = clamp_term(action_sum + mul_fix24(en - eo, kt));
        end
        if (is_last) begin
            sums_due.push_back('{action: action_sum[47:0], sat: clamp_seen});
            action_sum = 0;
            clamp_seen = 1'b0;
        end
    endtask

    task automatic report(string what, logic [47:0] got, logic [47:0] want);
        $display("%0t: %s mismatch, got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        move_result_t want;
        if (!aresetn) begin
            donor      = 65536;
            shift      = 0;
            barrier    = 0;
            strength   = 0;
            tau        = 64'd16777216;
            first_idx  = 0;
            count      = 0;
            action_sum = 0;
            clamp_seen = 1'b0;
            sums_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DONOR:    donor = longint'(cfg_data[30:0]);
                    REG_SHIFT:    shift = longint'(cfg_data[30:0]);
                    REG_BARRIER:  barrier = longint'($signed(cfg_data));
                    REG_STRENGTH: strength = longint'($signed(cfg_data));
                    REG_TIME:     tau = longint'(cfg_data);
                    REG_FIRST:    first_idx = longint'(cfg_data[9:0]);
                    REG_COUNT:    count = longint'(cfg_data[10:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                accept_bead(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (sums_due.size() == 0) begin
                    report("unexpected result", m_tdata[47:0], '0);
                end else begin
                    want = sums_due.pop_front();
                    if (m_tdata[47:0] !== want.action)
                        report("action_difference", m_tdata[47:0], want.action);
                    if (m_tdata[48] !== want.sat)
                        report("saturated", 48'(m_tdata[48]), 48'(want.sat));
                end
            end
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: image-charge action difference accumulator
// Drives directed beads, then random moves, across four register settings
// and four idling patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import icad_pkg::*;

    localparam int PHASE_BEADS = 450;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [207:0]         s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [55:0]          m_tdata;
    int                   fail_count;
    int                   pending;

    // shadow of the species range, used to aim most indices inside it
    int                   sp_first;
    int                   sp_count;
    // percentage of beads the sender idles before, and of cycles the receiver stalls
    int                   send_idle;
    int                   recv_stall;

    image_charge_action_difference i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    image_charge_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver: stall at random according to the current pattern
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // write one register, hold until the channel takes it, then idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_species(int first, int num);
        sp_first = first;
        sp_count = num;
        write_reg(REG_FIRST, 32'(first));
        write_reg(REG_COUNT, 32'(num));
    endtask

    // send one bead request; valid stays high into the next request unless idling
    task automatic send_bead(logic [9:0] idx, logic [31:0] nx, logic [31:0] ny,
                             logic [31:0] nz, logic [31:0] ox, logic [31:0] oy,
                             logic [31:0] oz, logic [2:0] lvl, logic is_last);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, lvl, oz, oy, ox, nz, ny, nx, idx};
        s_tlast  <= is_last;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    // drop valid and wait for every result, then for the block to go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (1000) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
            2: return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
            default: return $urandom & 32'h8001_FFFF;
        endcase
    endfunction

    function automatic logic [9:0] pick_index();
        int top;
        top = sp_first + sp_count;
        if (top > 1024)
            top = 1024;
        if (top > sp_first && $urandom_range(99) < 85)
            return 10'($urandom_range(sp_first, top - 1));
        return 10'($urandom);
    endfunction

    // random moves: mostly well-formed runs of beads closed by last
    task automatic random_moves(int beads, logic [31:0] donor, logic [31:0] shift);
        int          sent, len;
        logic [31:0] c [6];
        logic [31:0] s;
        sent = 0;
        s = donor + shift;
        while (sent < beads) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                foreach (c[j]) c[j] = pick_coord();
                // land on the image plane, the zero-root point or just below the barrier now and then
                case ($urandom_range(19))
                    0: c[2] = -s;
                    1: begin
                        c[0] = '0;
                        c[1] = '0;
                        c[2] = -(s << 1);
                    end
                    2: c[5] = -donor - 32'd1;
                    default: ;
                endcase
                send_bead(pick_index(), c[0], c[1], c[2], c[3], c[4], c[5],
                          3'($urandom), k == len - 1);
                sent++;
            end
        end
    endtask

    task automatic apply_setting(logic [31:0] d, logic [31:0] sh, logic [31:0] bar,
                                 logic [31:0] str, logic [31:0] tau, int first, int num);
        write_reg(REG_DONOR, d);
        write_reg(REG_SHIFT, sh);
        write_reg(REG_BARRIER, bar);
        write_reg(REG_STRENGTH, str);
        write_reg(REG_TIME, tau);
        set_species(first, num);
    endtask

    initial begin
        logic [31:0] d, sh;
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        sp_first   = 0;
        sp_count   = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // typical setting: d = 1.0, del = 0.25, species 100..699
        apply_setting(32'h0001_0000, 32'h0000_4000, 32'h0001_0000, 32'h0100_0000,
                      32'h0100_0000, 100, 600);

        // directed beads: plain move, root and plane singularities, barrier
        send_bead(10'd100, '0, '0, '0, '0, '0, '0, 3'd0, 1'b1);
        send_bead(10'd200, '0, '0, -32'sd163840, 32'h0001_0000, '0, '0, 3'd7, 1'b1);
        send_bead(10'd300, 32'h0000_8000, '0, -32'sd81920, '0, '0, 32'h0002_0000,
                  3'd1, 1'b0);
        send_bead(10'd699, '0, '0, -32'sd65537, '0, '0, '0, 3'd3, 1'b1);
        // field extremes
        send_bead(10'd400, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3'd7, 1'b0);
        send_bead(10'd500, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3'd0, 1'b1);
        // indices just outside the species range add nothing, last still emits
        send_bead(10'd0, 32'h0001_0000, '0, '0, '0, '0, '0, 3'd2, 1'b0);
        send_bead(10'd99, 32'h0001_0000, '0, '0, '0, '0, '0, 3'd2, 1'b0);
        send_bead(10'd700, 32'h0001_0000, '0, '0, '0, '0, '0, 3'd2, 1'b0);
        send_bead(10'd1023, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, 3'd5, 1'b1);
        send_bead(10'd150, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_1000,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_F000, 3'd4, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle = 57;
                    recv_stall = 0;
                end
                2: begin
                    send_idle = 0;
                    recv_stall = 57;
                end
                default: begin
                    send_idle = 19;
                    recv_stall = 19;
                end
            endcase
            case (ph)
                0: begin
                    d = 32'h0001_0000;
                    sh = 32'h0000_4000;
                end
                1: begin
                    // upper extremes; only index 1023 lies in the species
                    d = 32'h7FFF_FFFF;
                    sh = 32'h7FFF_FFFF;
                    drain();
                    apply_setting(d, sh, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                  1023, 1024);
                end
                2: begin
                    // lower extremes
                    d = '0;
                    sh = '0;
                    drain();
                    apply_setting(d, sh, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                  0, 0);
                    send_bead(10'd0, 32'h0001_0000, '0, '0, '0, '0, '0, 3'd0, 1'b1);
                    drain();
                    write_reg(REG_TIME, 32'h0000_0001);
                    set_species(0, 1024);
                end
                default: begin
                    d = $urandom_range(0, 32'h0008_0000);
                    sh = $urandom_range(0, 32'h0002_0000);
                    drain();
                    apply_setting(d, sh, $urandom, $urandom, $urandom_range(0, 32'h0400_0000),
                                  $urandom_range(0, 1023), $urandom_range(0, 1024));
                    // an index past the register list is ignored
                    write_reg(3'd7, $urandom);
                end
            endcase
            random_moves(PHASE_BEADS, d, sh);
        end

        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // hard limit on the run: far beyond the slowest correct run
    initial begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
design/icad_pkg.sv
design/icad_mul.sv
design/icad_div.sv
design/icad_sqrt.sv
design/icad_datapath.sv
design/icad_ctrl.sv
design/image_charge_action_difference.sv
dv/image_charge_checker.sv
dv/testbench.sv
